### sv/famr_pkg.sv
package famr_pkg;

  // Operation codes carried on operation_i
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_MUL = 2'd1;
  localparam logic [1:0] OP_CMP = 2'd2;

  // Sequencer states of the top level
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_GCD,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

### sv/famr_mul.sv
module famr_mul #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic [OPERAND_WIDTH-1:0]     a_i,
  input  logic [OPERAND_WIDTH-1:0]     b_i,
  output logic [2*OPERAND_WIDTH-1:0]   prod_o
);

  logic [2*OPERAND_WIDTH-1:0] prod_q;
  logic [2*OPERAND_WIDTH-1:0] prod_d;

  assign prod_d = (2*OPERAND_WIDTH)'(a_i) * (2*OPERAND_WIDTH)'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

### sv/famr_gcd.sv
module famr_gcd #(
  parameter int unsigned VAL_WIDTH = 33
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [VAL_WIDTH-1:0] x_i,
  input  logic [VAL_WIDTH-1:0] y_i,
  output logic                 done_o,
  output logic [VAL_WIDTH-1:0] gcd_o
);

  localparam int unsigned KW = (VAL_WIDTH > 1) ? $clog2(VAL_WIDTH) : 1;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [VAL_WIDTH-1:0] u_q, u_d;
  logic [VAL_WIDTH-1:0] v_q, v_d;
  logic [KW-1:0]        k_q, k_d;
  logic [VAL_WIDTH-1:0] g_q, g_d;

  // Binary gcd: strip common twos, then subtract odd values until one is zero
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    u_d    = u_q;
    v_d    = v_q;
    k_d    = k_q;
    g_d    = g_q;
    if (start_i) begin
      busy_d = 1'b1;
      u_d    = x_i;
      v_d    = y_i;
      k_d    = '0;
    end else if (busy_q) begin
      if (u_q == '0 || v_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        g_d    = (u_q | v_q) << k_q;
      end else if (!u_q[0] && !v_q[0]) begin
        u_d = u_q >> 1;
        v_d = v_q >> 1;
        k_d = k_q + 1'b1;
      end else if (!u_q[0]) begin
        u_d = u_q >> 1;
      end else if (!v_q[0]) begin
        v_d = v_q >> 1;
      end else if (u_q >= v_q) begin
        u_d = u_q - v_q;
      end else begin
        v_d = v_q - u_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q <= u_d;
    v_q <= v_d;
    k_q <= k_d;
    g_q <= g_d;
  end

  assign done_o = done_q;
  assign gcd_o  = g_q;

endmodule

### sv/famr_div.sv
module famr_div #(
  parameter int unsigned VAL_WIDTH = 33
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [VAL_WIDTH-1:0] num_i,
  input  logic [VAL_WIDTH-1:0] den_i,
  input  logic [VAL_WIDTH-1:0] divisor_i,
  output logic                 done_o,
  output logic [VAL_WIDTH-1:0] num_quot_o,
  output logic [VAL_WIDTH-1:0] den_quot_o
);

  localparam int unsigned CW = $clog2(VAL_WIDTH + 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [VAL_WIDTH-1:0] dvs_q, dvs_d;
  logic [VAL_WIDTH-1:0] qn_q, qn_d;
  logic [VAL_WIDTH-1:0] qd_q, qd_d;
  logic [VAL_WIDTH-1:0] rn_q, rn_d;
  logic [VAL_WIDTH-1:0] rd_q, rd_d;
  logic [VAL_WIDTH:0]   rn_sh, rd_sh;
  logic [VAL_WIDTH:0]   rn_sub, rd_sub;

  // Restoring division, one quotient bit per cycle, both dividends share the divisor
  assign rn_sh  = {rn_q, qn_q[VAL_WIDTH-1]};
  assign rd_sh  = {rd_q, qd_q[VAL_WIDTH-1]};
  assign rn_sub = rn_sh - {1'b0, dvs_q};
  assign rd_sub = rd_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvs_d  = dvs_q;
    qn_d   = qn_q;
    qd_d   = qd_q;
    rn_d   = rn_q;
    rd_d   = rd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(VAL_WIDTH);
      dvs_d  = divisor_i;
      qn_d   = num_i;
      qd_d   = den_i;
      rn_d   = '0;
      rd_d   = '0;
    end else if (busy_q) begin
      if (!rn_sub[VAL_WIDTH]) begin
        rn_d = rn_sub[VAL_WIDTH-1:0];
        qn_d = {qn_q[VAL_WIDTH-2:0], 1'b1};
      end else begin
        rn_d = rn_sh[VAL_WIDTH-1:0];
        qn_d = {qn_q[VAL_WIDTH-2:0], 1'b0};
      end
      if (!rd_sub[VAL_WIDTH]) begin
        rd_d = rd_sub[VAL_WIDTH-1:0];
        qd_d = {qd_q[VAL_WIDTH-2:0], 1'b1};
      end else begin
        rd_d = rd_sh[VAL_WIDTH-1:0];
        qd_d = {qd_q[VAL_WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_d;
    qn_q  <= qn_d;
    qd_q  <= qd_d;
    rn_q  <= rn_d;
    rd_q  <= rd_d;
  end

  assign done_o     = done_q;
  assign num_quot_o = qn_q;
  assign den_quot_o = qd_q;

endmodule

### sv/fraction_add_multiply_reduce.sv
// Fraction add / multiply with gcd reduction, plus raw-field compare.
//
// Input channel: in_valid_i / in_stall_o with operation_i and the four
// operand fields. A transfer happens when in_valid_i is high and in_stall_o
// is low; in_stall_o is low only while the block is idle.
// Output channel: out_valid_o / out_stall_i with result_num_o, result_den_o
// and is_equal_o. The result register holds its value while out_stall_i is
// high; the block takes no new item until the result has been transferred.
//
// Sequence: compare (and the unused code) shows its result in the cycle after
// the transfer. Add and multiply form three products through the shared
// registered multiplier in the ST_MUL states; a zero numerator or
// denominator then goes straight to the result register. Otherwise the
// binary gcd runs one compare/subtract or shift per cycle, hands its result
// to the shared-divisor restoring divider, and the quotients go to the
// result register. After the receiver takes the result the block returns to
// idle and then takes the next item.
// Reset clears the sequencer to idle with no result pending.
module fraction_add_multiply_reduce #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   operation_i,
  input  logic [OPERAND_WIDTH-1:0]     a_num_i,
  input  logic [OPERAND_WIDTH-1:0]     a_den_i,
  input  logic [OPERAND_WIDTH-1:0]     b_num_i,
  input  logic [OPERAND_WIDTH-1:0]     b_den_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2*OPERAND_WIDTH:0]     result_num_o,
  output logic [2*OPERAND_WIDTH-1:0]   result_den_o,
  output logic                         is_equal_o
);

  localparam int unsigned W     = OPERAND_WIDTH;
  localparam int unsigned NUM_W = 2 * OPERAND_WIDTH + 1;
  localparam int unsigned DEN_W = 2 * OPERAND_WIDTH;

  famr_pkg::state_e state_q, state_d;

  logic [1:0]       op_q, op_d;
  logic [W-1:0]     an_q, an_d;
  logic [W-1:0]     ad_q, ad_d;
  logic [W-1:0]     bn_q, bn_d;
  logic [W-1:0]     bd_q, bd_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [NUM_W-1:0] den_q, den_d;
  logic [NUM_W-1:0] res_num_q, res_num_d;
  logic [DEN_W-1:0] res_den_q, res_den_d;
  logic             res_eq_q, res_eq_d;

  logic [W-1:0]     mul_a, mul_b;
  logic [DEN_W-1:0] prod;
  logic [NUM_W-1:0] num_sum;

  logic             gcd_start, gcd_done;
  logic [NUM_W-1:0] gcd_val;
  logic             div_start, div_done;
  logic [NUM_W-1:0] quot_num, quot_den;

  logic             in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && (state_q == famr_pkg::ST_IDLE);
  assign out_xfer = (state_q == famr_pkg::ST_OUT) && !out_stall_i;

  famr_mul #(.OPERAND_WIDTH(W)) u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  famr_gcd #(.VAL_WIDTH(NUM_W)) u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .x_i     (num_q),
    .y_i     (NUM_W'(prod)),
    .done_o  (gcd_done),
    .gcd_o   (gcd_val)
  );

  famr_div #(.VAL_WIDTH(NUM_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .num_i      (num_q),
    .den_i      (den_q),
    .divisor_i  (gcd_val),
    .done_o     (div_done),
    .num_quot_o (quot_num),
    .den_quot_o (quot_den)
  );

  // Add numerator; above 64 result bits the carry bit is cleared and the sum wraps at 2*OPERAND_WIDTH bits
  always_comb begin
    num_sum = num_q + NUM_W'(prod);
    if (NUM_W > 64) begin
      num_sum[NUM_W-1] = 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      famr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (operation_i == famr_pkg::OP_ADD || operation_i == famr_pkg::OP_MUL) begin
            state_d = famr_pkg::ST_MUL0;
          end else begin
            state_d = famr_pkg::ST_OUT;
          end
        end
      end
      famr_pkg::ST_MUL0: state_d = famr_pkg::ST_MUL1;
      famr_pkg::ST_MUL1: state_d = famr_pkg::ST_MUL2;
      famr_pkg::ST_MUL2: state_d = famr_pkg::ST_MUL3;
      famr_pkg::ST_MUL3: begin
        if (num_q == '0 || prod == '0) begin
          state_d = famr_pkg::ST_OUT;
        end else begin
          state_d = famr_pkg::ST_GCD;
        end
      end
      famr_pkg::ST_GCD: begin
        if (gcd_done) begin
          state_d = famr_pkg::ST_DIV;
        end
      end
      famr_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = famr_pkg::ST_OUT;
        end
      end
      famr_pkg::ST_OUT: begin
        if (out_xfer) begin
          state_d = famr_pkg::ST_IDLE;
        end
      end
      default: state_d = famr_pkg::ST_IDLE;
    endcase
  end

  // Datapath control and result capture
  always_comb begin
    op_d      = op_q;
    an_d      = an_q;
    ad_d      = ad_q;
    bn_d      = bn_q;
    bd_d      = bd_q;
    num_d     = num_q;
    den_d     = den_q;
    res_num_d = res_num_q;
    res_den_d = res_den_q;
    res_eq_d  = res_eq_q;
    mul_a     = an_q;
    mul_b     = bn_q;
    gcd_start = 1'b0;
    div_start = 1'b0;
    case (state_q)
      famr_pkg::ST_IDLE: begin
        // Latch operands on transfer; compare finishes right here
        if (in_xfer) begin
          op_d      = operation_i;
          an_d      = a_num_i;
          ad_d      = a_den_i;
          bn_d      = b_num_i;
          bd_d      = b_den_i;
          res_num_d = '0;
          res_den_d = '0;
          res_eq_d  = (operation_i == famr_pkg::OP_CMP) &&
                      (a_num_i == b_num_i) && (a_den_i == b_den_i);
        end
      end
      famr_pkg::ST_MUL0: begin
        mul_a = an_q;
        mul_b = (op_q == famr_pkg::OP_ADD) ? bd_q : bn_q;
      end
      famr_pkg::ST_MUL1: begin
        num_d = NUM_W'(prod);
        mul_a = bn_q;
        mul_b = ad_q;
      end
      famr_pkg::ST_MUL2: begin
        if (op_q == famr_pkg::OP_ADD) begin
          num_d = num_sum;
        end
        mul_a = ad_q;
        mul_b = bd_q;
      end
      famr_pkg::ST_MUL3: begin
        den_d = NUM_W'(prod);
        if (num_q == '0 || prod == '0) begin
          // Zero numerator or denominator: pass through unreduced
          res_num_d = num_q;
          res_den_d = prod;
        end else begin
          gcd_start = 1'b1;
        end
      end
      famr_pkg::ST_GCD: begin
        div_start = gcd_done;
      end
      famr_pkg::ST_DIV: begin
        if (div_done) begin
          res_num_d = quot_num;
          res_den_d = quot_den[DEN_W-1:0];
        end
      end
      famr_pkg::ST_OUT: begin
        // Hold the result until the receiver takes it
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= famr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    an_q      <= an_d;
    ad_q      <= ad_d;
    bn_q      <= bn_d;
    bd_q      <= bd_d;
    num_q     <= num_d;
    den_q     <= den_d;
    res_num_q <= res_num_d;
    res_den_q <= res_den_d;
    res_eq_q  <= res_eq_d;
  end

  assign in_stall_o   = (state_q != famr_pkg::ST_IDLE);
  assign out_valid_o  = (state_q == famr_pkg::ST_OUT);
  assign result_num_o = res_num_q;
  assign result_den_o = res_den_q;
  assign is_equal_o   = res_eq_q;

endmodule

### sv/famr_check.sv
module famr_check #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [2*OPERAND_WIDTH:0]     result_num_o,
  input logic [2*OPERAND_WIDTH-1:0]   result_den_o,
  input logic                         is_equal_o
);

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_num_o) &&
      $stable(result_den_o) && $stable(is_equal_o))
    else $error("stalled result changed");

  // Input side is open only when no result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("input open while a result is pending");

  // A transfer in makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while busy");

  // An equal compare carries zero numerator and denominator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_equal_o |-> result_num_o == '0 && result_den_o == '0)
    else $error("compare result with nonzero fraction");

endmodule

bind fraction_add_multiply_reduce famr_check #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_famr_check (.*);
